// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge of clk_i, suspended while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- sv/lcat_pkg.sv -----
// ----------------------------------------------------------------------------
// lcat_pkg
// Types and codes shared by the toroidal life automaton modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lcat_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned BitsW = 16;

  typedef enum logic [OpW-1:0] {
    OP_WRITE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } lcat_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_COMMIT
  } lcat_state_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic shift;
    logic commit;
  } lcat_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/lcat_rule.sv -----
// ----------------------------------------------------------------------------
// lcat_rule
// Next-generation row from three old rows, B3/S23 with column wrap-around.
// ----------------------------------------------------------------------------
`default_nettype none

module lcat_rule #(
  parameter int unsigned SIDE = 16
) (
  input  logic [SIDE-1:0] up_row_i,
  input  logic [SIDE-1:0] mid_row_i,
  input  logic [SIDE-1:0] dn_row_i,
  output logic [SIDE-1:0] new_row_o
);

  for (genvar c = 0; c < SIDE; c++) begin : g_col
    localparam int unsigned Lf = (c + SIDE - 1) % SIDE;
    localparam int unsigned Rt = (c + 1) % SIDE;
    logic [3:0] nbr;

    assign nbr = {3'b000, up_row_i[Lf]} + {3'b000, up_row_i[c]} + {3'b000, up_row_i[Rt]}
               + {3'b000, mid_row_i[Lf]} + {3'b000, mid_row_i[Rt]}
               + {3'b000, dn_row_i[Lf]} + {3'b000, dn_row_i[c]} + {3'b000, dn_row_i[Rt]};

    assign new_row_o[c] = (nbr == 4'd3) || (mid_row_i[c] && (nbr == 4'd2));
  end

endmodule

`default_nettype wire

// ----- sv/lcat_cell.sv -----
// ----------------------------------------------------------------------------
// lcat_cell
// One grid row: the committed row and the next-generation row, both of which
// pass to the neighboring cell on every step of a generation.
// ----------------------------------------------------------------------------
`default_nettype none

module lcat_cell #(
  parameter int unsigned SIDE = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcat_pkg::lcat_ctrl_t ctrl_i,
  input  logic               wr_en_i,
  input  logic [SIDE-1:0]    wr_row_i,
  input  logic [SIDE-1:0]    old_nb_i,
  input  logic [SIDE-1:0]    nxt_nb_i,
  output logic [SIDE-1:0]    old_o,
  output logic [SIDE-1:0]    nxt_o
);

  import lcat_pkg::*;

  logic [SIDE-1:0] old_q, old_d;
  logic [SIDE-1:0] nxt_q, nxt_d;

  always_comb begin
    old_d = old_q;
    nxt_d = nxt_q;
    priority if (ctrl_i.shift) begin
      old_d = old_nb_i;
      nxt_d = nxt_nb_i;
    end else if (ctrl_i.commit) begin
      old_d = nxt_q;
    end else if (wr_en_i) begin
      old_d = wr_row_i;
    end else begin
      old_d = old_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_q <= '0;
    end else begin
      old_q <= old_d;
    end
  end

  // Every slot is overwritten during a generation before it is committed.
  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d;
  end

  assign old_o = old_q;
  assign nxt_o = nxt_q;

endmodule

`default_nettype wire

// ----- sv/lcat_seq.sv -----
// ----------------------------------------------------------------------------
// lcat_seq
// Generation sequencer: rotates the row ring SIDE times, then commits.
// ----------------------------------------------------------------------------
`default_nettype none

module lcat_seq #(
  parameter int unsigned SIDE = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 idle_o,
  output lcat_pkg::lcat_ctrl_t ctrl_o
);

  import lcat_pkg::*;

  localparam int unsigned CntW = $clog2(SIDE);
  localparam logic [CntW-1:0] CntLast = CntW'(SIDE - 1);

  lcat_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idle_o        = 1'b0;
    ctrl_o.shift  = 1'b0;
    ctrl_o.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        cnt_d  = '0;
        if (start_i) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        ctrl_o.shift = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        ctrl_o.commit = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/life_cellular_automaton_torus.sv -----
// ----------------------------------------------------------------------------
// life_cellular_automaton_torus
// B3/S23 life on a SIDE x SIDE torus held in a ring of row cells.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Fields (low bit first)
// s_axis   in   op[1:0], row_index[5:2], row_bits[21:6] in tdata[23:0]
// m_axis   out  read_bits[15:0] in tdata[15:0], one transfer per input item
//
// An advance holds off input through SIDE ring steps, in each of which the
// rule unit at the head of the ring produces one new row, and a commit step
// that updates all rows at once. Reset clears the committed row of every
// cell at once. While the sequencer is idle, the output register frees the
// input side whenever it is empty or being taken in the same cycle; while a
// result stalls on m_axis, no new item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module life_cellular_automaton_torus #(
  parameter int unsigned SIDE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // op[1:0], row_index[5:2], row_bits[21:6]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // read_bits[15:0]
);

  import lcat_pkg::*;

  logic [OpW-1:0]   op;
  logic [IdxW-1:0]  row_index;
  logic [BitsW-1:0] row_bits;

  assign op        = s_axis_tdata_i[1:0];
  assign row_index = s_axis_tdata_i[5:2];
  assign row_bits  = s_axis_tdata_i[21:6];

  logic       seq_idle;
  lcat_ctrl_t ctrl;
  logic       in_xfer;
  logic       do_write, do_read, do_advance;

  logic             m_valid_q, m_valid_d;
  logic [BitsW-1:0] m_data_q, m_data_d;

  assign s_axis_tready_o = seq_idle && (!m_valid_q || m_axis_tready_i);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    do_write   = 1'b0;
    do_read    = 1'b0;
    do_advance = 1'b0;
    unique case (op)
      OP_WRITE:   do_write   = in_xfer;
      OP_ADVANCE: do_advance = in_xfer;
      OP_READ:    do_read    = in_xfer;
      default:    ;
    endcase
  end

  lcat_seq #(.SIDE(SIDE)) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (do_advance),
    .idle_o  (seq_idle),
    .ctrl_o  (ctrl)
  );

  // Row bits widened or trimmed to the ring width.
  logic [SIDE+BitsW-1:0] wr_ext;
  logic [SIDE-1:0]       wr_row;
  assign wr_ext = {{SIDE{1'b0}}, row_bits};
  assign wr_row = wr_ext[SIDE-1:0];

  logic [SIDE-1:0] old_rows [SIDE];
  logic [SIDE-1:0] nxt_rows [SIDE];
  logic [SIDE-1:0] rule_row;

  // The head cell takes the new row of its upstream neighbor's row, so the
  // new ring stays aligned with the old ring as both rotate.
  lcat_rule #(.SIDE(SIDE)) u_rule (
    .up_row_i  (old_rows[0]),
    .mid_row_i (old_rows[1]),
    .dn_row_i  (old_rows[2]),
    .new_row_o (rule_row)
  );

  for (genvar k = 0; k < SIDE; k++) begin : g_cell
    localparam int unsigned Nb = (k + 1) % SIDE;
    logic            wr_en;
    logic [SIDE-1:0] nxt_nb;

    assign wr_en  = do_write && (32'(row_index) == k);
    assign nxt_nb = (k == 0) ? rule_row : nxt_rows[Nb];

    lcat_cell #(.SIDE(SIDE)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .wr_en_i  (wr_en),
      .wr_row_i (wr_row),
      .old_nb_i (old_rows[Nb]),
      .nxt_nb_i (nxt_nb),
      .old_o    (old_rows[k]),
      .nxt_o    (nxt_rows[k])
    );
  end

  // Row select for reads; an index past the last row reads as zero.
  logic [SIDE-1:0]       rd_row;
  logic [SIDE+BitsW-1:0] rd_ext;

  always_comb begin
    rd_row = '0;
    for (int k = 0; k < SIDE; k++) begin
      if (32'(row_index) == k) begin
        rd_row = old_rows[k];
      end
    end
  end

  assign rd_ext = {{BitsW{1'b0}}, rd_row};

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (in_xfer) begin
      m_valid_d = 1'b1;
      m_data_d  = do_read ? rd_ext[BitsW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `ASSERT_CLK(a_adv_starts_ring, do_advance |=> ctrl.shift, "advance did not start the ring")
  `ASSERT_CLK_ALWAYS(a_ctrl_excl, !(ctrl.shift && ctrl.commit), "shift and commit together")
  `ASSERT_CLK(a_commit_ends, ctrl.commit |=> seq_idle, "sequencer not idle after commit")
  `ASSERT_CLK(a_xfer_gives_result, in_xfer |=> m_valid_q, "accepted item gave no result")
  `ASSERT_CLK(a_busy_blocks_in, !seq_idle |-> !in_xfer, "item taken during a generation")

endmodule

`default_nettype wire
